[rtl/flrrs_pkg.sv]
package flrrs_pkg;

	localparam int QUEUE_DEPTH_DEF = 128;
	localparam int LEVELS_DEF      = 4;
	localparam int TAG_BITS_DEF    = 16;

	localparam logic CMD_SUBMIT = 1'b0;
	localparam logic CMD_SLICE  = 1'b1;

	typedef enum logic [1:0] {
		OUT_OK       = 2'd0,
		OUT_BAD_PRIO = 2'd1,
		OUT_FULL     = 2'd2,
		OUT_EMPTY    = 2'd3
	} outcome_t;

	// per-item result status, handed from queue control to the output side
	typedef struct packed {
		logic       valid;   // a job was dispatched
		logic [2:0] level;   // 1-based level of the dispatched job
		outcome_t   outcome;
		logic       bypass;  // dispatched tag is the one just put back
	} grant_t;

endpackage

[rtl/flrrs_store.sv]
module flrrs_store import flrrs_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF * LEVELS_DEF,
	parameter int DW    = TAG_BITS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/flrrs_queue_ctrl.sv]
module flrrs_queue_ctrl import flrrs_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int LEVELS      = LEVELS_DEF,
	parameter int TAG_BITS    = TAG_BITS_DEF,
	parameter int AW          = $clog2(QUEUE_DEPTH * LEVELS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                proc,
	input  logic                cmd,
	input  logic [TAG_BITS-1:0] tag,
	input  logic [2:0]          prio,
	input  logic                fin,
	input  logic [TAG_BITS-1:0] run_tag,
	output logic                mem_we,
	output logic [AW-1:0]       mem_waddr,
	output logic [TAG_BITS-1:0] mem_wdata,
	output logic                mem_re,
	output logic [AW-1:0]       mem_raddr,
	output grant_t              res
);

	localparam int LW = $clog2(LEVELS);
	localparam int SW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [SW-1:0] head_q [LEVELS];
	logic [CW-1:0] fill_q [LEVELS];
	logic          run_valid_q;
	logic [LW-1:0] run_level_q;

	logic          slice;
	logic [2:0]    prio_eff;
	logic          bad;
	logic [LW-1:0] push_lv;
	logic          push_want;
	logic          full;
	logic          push_ok;
	logic [SW-1:0] push_slot;
	logic [SW+1:0] slot_sum;
	logic [LEVELS-1:0] push_oh;
	logic [LEVELS-1:0] nonempty;
	logic          found;
	logic [LW-1:0] sel;
	logic [SW-1:0] sel_head;
	logic [CW-1:0] sel_fill;
	logic [3:0]    lvl4;

	always_comb begin
		slice     = (cmd == CMD_SLICE);
		prio_eff  = (prio == 3'd0) ? 3'd1 : prio;
		bad       = ({1'b0, prio_eff} > 4'(LEVELS));
		push_lv   = slice ? run_level_q : LW'(prio_eff - 3'd1);
		push_want = slice ? (run_valid_q && !fin) : !bad;

		full      = 1'b0;
		push_slot = '0;
		slot_sum  = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (push_lv == LW'(l)) begin
				full     = (fill_q[l] == CW'(QUEUE_DEPTH));
				slot_sum = (SW+2)'(head_q[l]) + (SW+2)'(fill_q[l]);
			end
		end
		if (slot_sum >= (SW+2)'(QUEUE_DEPTH)) begin
			push_slot = SW'(slot_sum - (SW+2)'(QUEUE_DEPTH));
		end else begin
			push_slot = SW'(slot_sum);
		end
		push_ok = push_want && !full;

		// a level counts as occupied if a put-back is landing in it now
		found = 1'b0;
		sel   = '0;
		for (int l = 0; l < LEVELS; l++) begin
			push_oh[l]  = push_ok && (push_lv == LW'(l));
			nonempty[l] = (fill_q[l] != '0) || push_oh[l];
			if (nonempty[l]) begin
				found = 1'b1;
				sel   = LW'(l);
			end
		end
		found = found && slice;

		sel_head = '0;
		sel_fill = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (sel == LW'(l)) begin
				sel_head = head_q[l];
				sel_fill = fill_q[l];
			end
		end

		mem_we    = proc && push_ok;
		mem_waddr = AW'(AW'(push_lv) * AW'(QUEUE_DEPTH)) + AW'(push_slot);
		mem_wdata = slice ? run_tag : tag;
		mem_re    = proc && found;
		mem_raddr = AW'(AW'(sel) * AW'(QUEUE_DEPTH)) + AW'(sel_head);

		lvl4        = 4'(sel) + 4'd1;
		res.valid   = found;
		res.level   = found ? lvl4[2:0] : 3'd0;
		res.bypass  = (sel_fill == '0);
		if (!slice) begin
			res.outcome = bad ? OUT_BAD_PRIO : (full ? OUT_FULL : OUT_OK);
		end else if (!found) begin
			res.outcome = OUT_EMPTY;
		end else begin
			res.outcome = (push_want && full) ? OUT_FULL : OUT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l] <= '0;
				fill_q[l] <= '0;
			end
			run_valid_q <= 1'b0;
			run_level_q <= '0;
		end else if (proc) begin
			for (int l = 0; l < LEVELS; l++) begin
				if (found && sel == LW'(l)) begin
					head_q[l] <= (head_q[l] == SW'(QUEUE_DEPTH - 1)) ? '0 : head_q[l] + 1'b1;
					if (!push_oh[l]) begin
						fill_q[l] <= fill_q[l] - 1'b1;
					end
				end else if (push_oh[l]) begin
					fill_q[l] <= fill_q[l] + 1'b1;
				end
			end
			if (slice) begin
				run_valid_q <= found;
				run_level_q <= sel;
			end
		end
	end

endmodule

[rtl/four_level_round_robin_scheduler.sv]
// channel | dir | fields, lowest bit first
// s_*     | in  | tdata: job_tag, priority_req, finished; tuser: command
// m_*     | out | tdata: grant_valid, grant_tag, grant_level, outcome
//
// One transfer per cycle sustained while m_tready stays high.
// Stages: input register, queue update with job store read, result register.
// The job store read is registered; a dispatch of the job just put back is bypassed.
// Reset clears pointers, fill counts and the running job; the store needs no clearing.
// A stall on the master side backs up through both stages to s_tready.
module four_level_round_robin_scheduler import flrrs_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int LEVELS      = LEVELS_DEF,
	parameter int TAG_BITS    = TAG_BITS_DEF,
	parameter int IW          = ((TAG_BITS + 4 + 7) / 8) * 8,
	parameter int OW          = ((TAG_BITS + 6 + 7) / 8) * 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [IW-1:0] s_tdata,   // job_tag, priority_req[2:0], finished
	input  logic [0:0]    s_tuser,   // command
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [OW-1:0] m_tdata    // grant_valid, grant_tag, grant_level[2:0], outcome[1:0]
);

	localparam int AW = $clog2(QUEUE_DEPTH * LEVELS);

	logic                valid_s1;
	logic                cmd_s1;
	logic [TAG_BITS-1:0] tag_s1;
	logic [2:0]          prio_s1;
	logic                fin_s1;

	logic                valid_s2;
	grant_t              res_s2;
	logic [TAG_BITS-1:0] byp_tag_s2;

	logic                out_valid_q;
	logic [OW-1:0]       out_data_q;
	logic [TAG_BITS-1:0] running_tag_q;

	logic                proc;
	logic                move_s2;
	grant_t              res;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [TAG_BITS-1:0] mem_wdata;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	logic [TAG_BITS-1:0] rdata;
	logic [TAG_BITS-1:0] resolved;
	logic [TAG_BITS-1:0] run_tag;

	assign move_s2  = valid_s2 && (!out_valid_q || m_tready);
	assign proc     = valid_s1 && (!valid_s2 || move_s2);
	assign s_tready = !valid_s1 || proc;

	assign resolved = res_s2.bypass ? byp_tag_s2 : rdata;
	// dispatched tag is still in flight while s2 holds it
	assign run_tag  = (valid_s2 && res_s2.valid) ? resolved : running_tag_q;

	flrrs_queue_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.LEVELS      (LEVELS),
		.TAG_BITS    (TAG_BITS),
		.AW          (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.proc      (proc),
		.cmd       (cmd_s1),
		.tag       (tag_s1),
		.prio      (prio_s1),
		.fin       (fin_s1),
		.run_tag   (run_tag),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.res       (res)
	);

	flrrs_store #(
		.DEPTH (QUEUE_DEPTH * LEVELS),
		.DW    (TAG_BITS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser[0];
			tag_s1  <= s_tdata[TAG_BITS-1:0];
			prio_s1 <= s_tdata[TAG_BITS+2:TAG_BITS];
			fin_s1  <= s_tdata[TAG_BITS+3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (proc) begin
			valid_s2 <= 1'b1;
		end else if (move_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			res_s2     <= res;
			byp_tag_s2 <= run_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_tag_q <= '0;
		end else if (valid_s2 && res_s2.valid) begin
			running_tag_q <= resolved;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s2) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2) begin
			out_data_q <= OW'({res_s2.outcome, res_s2.level,
				(res_s2.valid ? resolved : {TAG_BITS{1'b0}}), res_s2.valid});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
